FILE: rtl/spq_pkg.sv
// shared types and codes for the sorted array priority queue
`timescale 1ns / 1ps

package spq_pkg;

    // operation codes carried on the request tuser
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    localparam int PRIO_W  = 16;
    localparam int VALUE_W = 32;
    localparam int OCC_W   = 4;

    typedef logic [PRIO_W-1:0]  prio_t;
    typedef logic [VALUE_W-1:0] value_t;

    // command broadcast to every cell
    typedef struct packed {
        logic   en;
        logic   enq;
        prio_t  prio;
        value_t value;
    } cell_cmd_t;

endpackage

FILE: rtl/spq_cell.sv
// one slot of the sorted chain: holds an entry and trades it with its neighbours
`timescale 1ns / 1ps

module spq_cell
(
    input  logic               clk,
    input  spq_pkg::cell_cmd_t cmd,
    input  logic               occ,
    input  logic               left_stay,
    input  spq_pkg::prio_t     left_prio,
    input  spq_pkg::value_t    left_value,
    input  spq_pkg::prio_t     right_prio,
    input  spq_pkg::value_t    right_value,
    output logic               stay,
    output spq_pkg::prio_t     prio,
    output spq_pkg::value_t    value
);

    spq_pkg::prio_t  prio_reg;
    spq_pkg::prio_t  prio_next;
    spq_pkg::value_t value_reg;
    spq_pkg::value_t value_next;

    // entry keeps its slot when it is held and not behind the new priority
    assign stay  = occ && (prio_reg <= cmd.prio);
    assign prio  = prio_reg;
    assign value = value_reg;

    // next contents: keep, take the new entry, shift back or shift forward
    always_comb
    begin
        prio_next  = prio_reg;
        value_next = value_reg;
        if (cmd.en)
        begin
            if (cmd.enq)
            begin
                if (!stay)
                begin
                    if (left_stay)
                    begin
                        prio_next  = cmd.prio;
                        value_next = cmd.value;
                    end
                    else
                    begin
                        prio_next  = left_prio;
                        value_next = left_value;
                    end
                end
            end
            else
            begin
                prio_next  = right_prio;
                value_next = right_value;
            end
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        prio_reg  <= prio_next;
        value_reg <= value_next;
    end

endmodule

FILE: rtl/sorted_array_priority_queue_top.sv
// top level of the sorted array priority queue
`timescale 1ns / 1ps

// Bounded priority queue of DEPTH entries kept sorted in a chain of cells,
// smallest priority number at the head, equal priorities in arrival order.
// On each request all cells compare their priority with the incoming one
// in parallel and shift by at most one place in the same edge, so a new
// request is taken every cycle while the result register is free or being
// drained. Each request gives exactly one result in the next cycle in a
// single output register. An enqueue into a full queue returns status
// full, a dequeue from an empty queue returns status empty; neither changes
// the contents. Slot contents have no reset; only held slots are ever read.

module sorted_array_priority_queue_top
#(
    parameter int DEPTH = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // prio_in[15:0], value_in[47:16]
    input  logic        s_tuser,   // func[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // prio_out[15:0], value_out[47:16], occupancy[51:48], zeros
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic               m_tvalid_reg;
    logic               m_tvalid_next;
    spq_pkg::status_t   status_reg;
    spq_pkg::status_t   status_next;
    spq_pkg::prio_t     prio_out_reg;
    spq_pkg::prio_t     prio_out_next;
    spq_pkg::value_t    value_out_reg;
    spq_pkg::value_t    value_out_next;
    logic [CW-1:0]      occ_out_reg;

    logic               accept;
    logic               enq;
    logic               full;
    logic               empty;
    spq_pkg::cell_cmd_t cmd;

    spq_pkg::prio_t     prio_w  [DEPTH];
    spq_pkg::value_t    value_w [DEPTH];
    logic               stay_w  [DEPTH+1];

    // request handshake, free when the result register is empty or draining
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign enq      = (s_tuser == spq_pkg::OP_ENQ);
    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);

    // command to the chain
    assign cmd.en    = accept && (enq ? !full : !empty);
    assign cmd.enq   = enq;
    assign cmd.prio  = s_tdata[15:0];
    assign cmd.value = s_tdata[47:16];

    // the head boundary always counts as a staying entry
    assign stay_w[0] = 1'b1;

    // chain of cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic occ;
        assign occ = (count_reg > CW'(i));

        spq_cell u_cell
        (
            .clk         (clk),
            .cmd         (cmd),
            .occ         (occ),
            .left_stay   (stay_w[i]),
            .left_prio   ((i == 0) ? s_tdata[15:0]  : prio_w[(i == 0) ? 0 : i-1]),
            .left_value  ((i == 0) ? s_tdata[47:16] : value_w[(i == 0) ? 0 : i-1]),
            .right_prio  (prio_w[(i == DEPTH-1) ? i : i+1]),
            .right_value (value_w[(i == DEPTH-1) ? i : i+1]),
            .stay        (stay_w[i+1]),
            .prio        (prio_w[i]),
            .value       (value_w[i])
        );
    end

    // fill count and result
    always_comb
    begin
        count_next     = count_reg;
        status_next    = status_reg;
        prio_out_next  = prio_out_reg;
        value_out_next = value_out_reg;
        m_tvalid_next  = m_tvalid_reg;
        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (accept)
        begin
            m_tvalid_next  = 1'b1;
            prio_out_next  = '0;
            value_out_next = '0;
            status_next    = spq_pkg::ST_OK;
            if (enq)
            begin
                if (full)
                begin
                    status_next = spq_pkg::ST_FULL;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            else
            begin
                if (empty)
                begin
                    status_next = spq_pkg::ST_EMPTY;
                end
                else
                begin
                    count_next     = count_reg - 1'b1;
                    prio_out_next  = prio_w[0];
                    value_out_next = value_w[0];
                end
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        status_reg    <= status_next;
        prio_out_reg  <= prio_out_next;
        value_out_reg <= value_out_next;
        if (accept)
        begin
            occ_out_reg <= count_next;
        end
    end

    // result port
    logic [CW+3:0] occ_wide;
    assign occ_wide = {4'b0000, occ_out_reg};

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {4'b0000, occ_wide[3:0], value_out_reg, prio_out_reg};

endmodule

FILE: rtl/spq_checker.sv
// port-level checks for the sorted array priority queue
`timescale 1ns / 1ps

module spq_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // every taken request shows a result on the next cycle
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("request gave no result");

    // refused enqueue carries no entry
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == spq_pkg::ST_FULL |-> m_tdata[47:0] == 48'd0)
        else $error("full result carries data");

    // empty dequeue carries no entry and an empty count
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == spq_pkg::ST_EMPTY |-> m_tdata[51:0] == 52'd0)
        else $error("empty result carries data or count");

endmodule

bind sorted_array_priority_queue_top spq_checker u_spq_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
